FILE: rtl/ptds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptds_pkg;

    localparam logic [1:0] ACT_ADD    = 2'd0;
    localparam logic [1:0] ACT_REMOVE = 2'd1;
    localparam logic [1:0] ACT_SCHED  = 2'd2;

    localparam logic [30:0] WAIT_LIMIT = 31'h7fffffff;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  slot;
        logic [7:0]  task_ident;
        logic [7:0]  prio;
        logic [15:0] period;
        logic [15:0] first_delay;
    } in_item_t;

    typedef struct packed {
        logic        dispatch_valid;
        logic [7:0]  task_out;
        logic [30:0] next_wait;
        logic        last;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // latch input beat
        logic write_slot; // apply add / remove
        logic scan_clear; // start a scan over the table
        logic scan_step;  // examine slot at scan index
        logic sel_clear;  // start a selection sweep
        logic sel_step;   // compare candidate at scan index
        logic commit;     // dispatch selected task, add period back
        logic fix_wait;   // finish next wait computation
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_sched;
        logic scan_done;
        logic any_due;
        logic more_due;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/ptds_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module ptds_datapath #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ptds_pkg::in_item_t  item,
    input  wire ptds_pkg::dp_cmd_t   cmd,
    output ptds_pkg::dp_stat_t       stat,
    output ptds_pkg::out_item_t      result
);

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    ptds_pkg::in_item_t item_reg;

    logic [MAX_TASKS-1:0] used_reg;
    logic [MAX_TASKS-1:0] due_reg;
    logic [7:0]           ident_mem  [MAX_TASKS];
    logic [7:0]           prio_mem   [MAX_TASKS];
    logic [15:0]          period_mem [MAX_TASKS];
    logic signed [31:0]   rem_mem    [MAX_TASKS];

    logic [30:0]        elapsed_reg;
    logic signed [32:0] next_reg;   // running minimum, wide enough for rem + period
    logic [CW-1:0]      idx_reg;
    logic               any_reg;

    logic               found_reg;
    logic [IW-1:0]      best_reg;
    logic [7:0]         best_prio_reg;
    logic signed [31:0] best_rem_reg;

    logic [IW-1:0]      idx;
    logic               slot_ok;
    logic signed [32:0] diff;
    logic signed [31:0] sub_sat;
    logic signed [32:0] sum;
    logic signed [32:0] add_back;
    logic signed [31:0] add_sat;
    logic               better;
    logic [MAX_TASKS-1:0] due_left;  // due set once the selected slot leaves

    assign idx     = idx_reg[IW-1:0];
    assign slot_ok = ({28'd0, item_reg.slot} < 32'(MAX_TASKS));

    always_comb
    begin
        diff    = 33'(rem_mem[idx]) - $signed({2'b00, elapsed_reg});
        sub_sat = (diff < -33'sd2147483648) ? 32'sh80000000 : diff[31:0];
        sum     = 33'(sub_sat) + $signed({17'd0, period_mem[idx]});
        add_back = 33'(rem_mem[best_reg]) + $signed({17'd0, period_mem[best_reg]});
        add_sat  = (add_back > 33'sd2147483647) ? 32'sh7fffffff : add_back[31:0];
        better = !found_reg
              || (prio_mem[idx] < best_prio_reg)
              || ((prio_mem[idx] == best_prio_reg) && (rem_mem[idx] < best_rem_reg));
        due_left = due_reg;
        due_left[best_reg] = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            due_reg     <= '0;
            elapsed_reg <= 31'd1;
            idx_reg     <= '0;
            any_reg     <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.write_slot && slot_ok)
            begin
                if (item_reg.action == ptds_pkg::ACT_ADD)
                    used_reg[item_reg.slot[IW-1:0]] <= 1'b1;
                else if (item_reg.action == ptds_pkg::ACT_REMOVE)
                    used_reg[item_reg.slot[IW-1:0]] <= 1'b0;
            end
            if (cmd.scan_clear || cmd.sel_clear)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.scan_clear)
            begin
                any_reg <= 1'b0;
                due_reg <= '0;
            end
            if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (used_reg[idx] && (sub_sat <= 0))
                begin
                    due_reg[idx] <= 1'b1;
                    any_reg      <= 1'b1;
                end
            end
            if (cmd.sel_step)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (due_reg[idx] && better)
                    found_reg <= 1'b1;
            end
            if (cmd.commit)
                due_reg[best_reg] <= 1'b0;
            if (cmd.fix_wait)
            begin
                if (next_reg < 33'sd1 || next_reg == 33'sh07fffffff)
                    elapsed_reg <= 31'd1;
                else
                    elapsed_reg <= next_reg[30:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= item;
        if (cmd.write_slot && slot_ok && item_reg.action == ptds_pkg::ACT_ADD)
        begin
            ident_mem[item_reg.slot[IW-1:0]]  <= item_reg.task_ident;
            prio_mem[item_reg.slot[IW-1:0]]   <= item_reg.prio;
            period_mem[item_reg.slot[IW-1:0]] <= item_reg.period;
            rem_mem[item_reg.slot[IW-1:0]]    <= $signed({16'd0, item_reg.first_delay});
        end
        if (cmd.scan_clear)
            next_reg <= 33'h07fffffff;
        if (cmd.scan_step && used_reg[idx])
        begin
            rem_mem[idx] <= sub_sat;
            if (sub_sat > 0)
            begin
                if (33'(sub_sat) < next_reg)
                    next_reg <= 33'(sub_sat);
            end
            else if (sum < next_reg)
                next_reg <= sum;
        end
        if (cmd.sel_step && due_reg[idx] && better)
        begin
            best_reg      <= idx;
            best_prio_reg <= prio_mem[idx];
            best_rem_reg  <= rem_mem[idx];
        end
        if (cmd.commit)
            rem_mem[best_reg] <= add_sat;
    end

    // result fields; strobe comes from the controller
    always_comb
    begin
        result.dispatch_valid = cmd.commit;
        result.task_out       = cmd.commit ? ident_mem[best_reg] : 8'd0;
        result.next_wait      = elapsed_reg;
        result.last           = !cmd.commit || !(|due_left);
    end

    assign stat.is_sched  = (item_reg.action == ptds_pkg::ACT_SCHED);
    assign stat.scan_done = (idx_reg == CW'(MAX_TASKS - 1));
    assign stat.any_due   = any_reg;
    assign stat.more_due  = |due_left;

endmodule

`default_nettype wire

FILE: rtl/ptds_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ptds_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire ptds_pkg::dp_stat_t stat,
    output logic                    busy,
    output logic                    done,
    output ptds_pkg::dp_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_WAIT   = 3'd3;
    localparam logic [2:0] S_SEL    = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;
    localparam logic [2:0] S_ACK    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        done       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.is_sched)
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    cmd.write_slot = 1'b1;
                    state_next     = S_ACK;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                    state_next = S_WAIT;
            end
            S_WAIT:
            begin
                cmd.fix_wait = 1'b1;
                if (stat.any_due)
                begin
                    cmd.sel_clear = 1'b1;
                    state_next    = S_SEL;
                end
                else
                    state_next = S_ACK;
            end
            S_SEL:
            begin
                cmd.sel_step = 1'b1;
                if (stat.scan_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.commit = 1'b1;
                done       = 1'b1;
                if (stat.more_due)
                begin
                    cmd.sel_clear = 1'b1;
                    state_next    = S_SEL;
                end
                else
                    state_next = S_IDLE;
            end
            S_ACK:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/periodic_task_dispatch_scheduler_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                      Beat taken when
// -------   ------------------------   ------------------------
// input     start, busy, item          start && !busy
// result    result_valid, result       result_valid (one cycle)
//
// Add / remove: after accept, a decode state, then the acknowledge beat.
// Schedule pass: a decode state, a scan over all slots and a wait state, then
// for each due task a selection sweep over all slots and one emit beat.
// A pass with nothing due ends with one acknowledge beat.
// Reset clears slot occupancy and sets the elapsed count to one.
// Results cannot be stalled; busy stays high until the final beat is out.

module periodic_task_dispatch_scheduler_top #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire ptds_pkg::in_item_t   item,
    output logic                      result_valid,
    output ptds_pkg::out_item_t       result
);

    ptds_pkg::dp_cmd_t  cmd;
    ptds_pkg::dp_stat_t stat;

    ptds_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .done  (result_valid),
        .cmd   (cmd)
    );

    ptds_datapath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

    a_wait_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.next_wait != 31'd0)
        else $error("next_wait of zero");

    a_no_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result beat while idle");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |=> !busy)
        else $error("busy after last beat");

    a_ack_no_task: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.dispatch_valid |-> result.task_out == 8'd0)
        else $error("task_out set without dispatch");

endmodule

`default_nettype wire
